// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL; sorted_min_priority_queue is the file that uses them.
// Depends on nothing; files that assert take it in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Concurrent property checked at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/smpq_pkg.sv =====
// Types, constants and the key comparison of the sorted priority queue.
// Depends on nothing; used by smpq_cell and sorted_min_priority_queue.
package smpq_pkg;

  localparam int unsigned CAPACITY         = 256;
  localparam int unsigned WEIGHT_BITS      = 32;
  localparam int unsigned HANDLE_BITS      = 9;
  localparam int unsigned SYMBOL_BITS      = 8;
  localparam int unsigned WEIGHT_PORT_BITS = 32;
  localparam int unsigned COUNT_BITS       = $clog2(CAPACITY + 1);

  // One stored entry.
  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [WEIGHT_BITS-1:0] weight;
    logic [SYMBOL_BITS-1:0] symbol;
  } entry_t;

  // Shift commands broadcast to every cell.
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Weight first, symbol breaks ties.
  function automatic logic key_less(entry_t a, entry_t b);
    logic res;
    if (a.weight == b.weight) begin
      res = a.symbol < b.symbol;
    end else begin
      res = a.weight < b.weight;
    end
    return res;
  endfunction

endpackage

// ===== rtl/smpq_cell.sv =====
// One slot of the shift-register priority queue.
// Depends on smpq_pkg for the entry type, the commands and the key compare.
module smpq_cell (
  input  logic                clk_i,
  input  smpq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occupied_i,
  input  smpq_pkg::entry_t    new_entry_i,
  input  smpq_pkg::entry_t    left_entry_i,
  input  logic                left_less_i,
  input  smpq_pkg::entry_t    right_entry_i,
  output smpq_pkg::entry_t    entry_o,
  output logic                less_o
);
  import smpq_pkg::*;

  entry_t entry_q, entry_d;

  // The new entry goes before this slot if the slot is free or holds a greater key.
  assign less_o  = !occupied_i || key_less(new_entry_i, entry_q);
  assign entry_o = entry_q;

  // On insert the first slot past the key takes the new entry and later slots
  // take their left neighbor; on removal all but the last take their right neighbor.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.enq) begin
      if (less_o) begin
        entry_d = left_less_i ? left_entry_i : new_entry_i;
      end
    end else if (ctrl_i.deq) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== rtl/sorted_min_priority_queue.sv =====
// Top level of the sorted min-priority queue: a row of smpq_cell slots,
// the occupancy count and the result register. Depends on smpq_pkg.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-------------------------------------
//   in      | input     | in_valid_i / in_stall_o  | op, node_handle, weight, symbol
//   out     | output    | out_valid_o / out_stall_i| out_handle, out_weight, out_symbol,
//           |           |                          | now_empty, now_single, status
//
// One beat per cycle unless stalled; its result is in the output register the cycle after.
// All slots compare the new key at once and shift in the same cycle, so the rate is
// set by one key compare per slot and the broadcast insert decision.
// Reset clears the count and the output valid; slot contents are not reset.
// A stalled result holds, and the input stalls only while that result is stalled.
module sorted_min_priority_queue (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  op_i,
  input  logic [smpq_pkg::HANDLE_BITS-1:0]      node_handle_i,
  input  logic [smpq_pkg::WEIGHT_PORT_BITS-1:0] weight_i,
  input  logic [smpq_pkg::SYMBOL_BITS-1:0]      symbol_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [smpq_pkg::HANDLE_BITS-1:0]      out_handle_o,
  output logic [smpq_pkg::WEIGHT_PORT_BITS-1:0] out_weight_o,
  output logic [smpq_pkg::SYMBOL_BITS-1:0]      out_symbol_o,
  output logic                                  now_empty_o,
  output logic                                  now_single_o,
  output logic [1:0]                            status_o
);
  import smpq_pkg::*;

  `include "assert_macros.svh"

  logic [COUNT_BITS-1:0]       count_q, count_d;
  logic                        out_valid_q;
  logic [HANDLE_BITS-1:0]      out_handle_q, out_handle_d;
  logic [WEIGHT_PORT_BITS-1:0] out_weight_q, out_weight_d;
  logic [SYMBOL_BITS-1:0]      out_symbol_q, out_symbol_d;
  logic                        now_empty_q, now_single_q;
  status_e                     status_q, status_d;

  logic       accept;
  logic       is_enq;
  logic       is_full;
  logic       is_empty;
  cell_ctrl_t cell_ctrl;
  entry_t     new_entry;
  entry_t     cell_entry [CAPACITY];
  logic       cell_less  [CAPACITY];

  // Input beat handshake and the shift commands.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_enq     = op_e'(op_i) == OP_ENQ;
  assign is_full    = count_q == COUNT_BITS'(CAPACITY);
  assign is_empty   = count_q == '0;

  assign cell_ctrl.enq = accept && is_enq && !is_full;
  assign cell_ctrl.deq = accept && !is_enq && !is_empty;

  assign new_entry.handle = node_handle_i;
  assign new_entry.weight = WEIGHT_BITS'(weight_i);
  assign new_entry.symbol = symbol_i;

  // Row of slots, least entry in slot zero.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occupied;
    entry_t left_entry;
    logic   left_less;
    entry_t right_entry;

    assign occupied = count_q > COUNT_BITS'(i);

    if (i == 0) begin : g_first
      assign left_entry = new_entry;
      assign left_less  = 1'b0;
    end else begin : g_inner_left
      assign left_entry = cell_entry[i-1];
      assign left_less  = cell_less[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = cell_entry[i];
    end else begin : g_inner_right
      assign right_entry = cell_entry[i+1];
    end

    smpq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (cell_ctrl),
      .occupied_i    (occupied),
      .new_entry_i   (new_entry),
      .left_entry_i  (left_entry),
      .left_less_i   (left_less),
      .right_entry_i (right_entry),
      .entry_o       (cell_entry[i]),
      .less_o        (cell_less[i])
    );
  end

  // Next count and the result of the accepted beat.
  always_comb begin
    count_d      = count_q;
    out_handle_d = '0;
    out_weight_d = '0;
    out_symbol_d = '0;
    status_d     = ST_OK;
    if (is_enq) begin
      if (is_full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (is_empty) begin
        status_d = ST_EMPTY;
      end else begin
        count_d      = count_q - 1'b1;
        out_handle_d = cell_entry[0].handle;
        out_weight_d = WEIGHT_PORT_BITS'(cell_entry[0].weight);
        out_symbol_d = cell_entry[0].symbol;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, loaded only when a beat is accepted.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_handle_q <= out_handle_d;
      out_weight_q <= out_weight_d;
      out_symbol_q <= out_symbol_d;
      now_empty_q  <= count_d == '0;
      now_single_q <= count_d == COUNT_BITS'(1);
      status_q     <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_handle_o = out_handle_q;
  assign out_weight_o = out_weight_q;
  assign out_symbol_o = out_symbol_q;
  assign now_empty_o  = now_empty_q;
  assign now_single_o = now_single_q;
  assign status_o     = status_q;

  // The count never passes the number of slots.
  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > COUNT_BITS'(CAPACITY))
  // A successful insert grows the count by exactly one.
  `ASSERT_PROP(a_enq_count, clk_i, rst_ni, cell_ctrl.enq |=> count_q == $past(count_q) + 1'b1)
  // A removal from an empty queue reports so and leaves the queue empty.
  `ASSERT_PROP(a_deq_empty, clk_i, rst_ni, accept && !is_enq && is_empty |=> out_valid_q && status_q == ST_EMPTY && now_empty_q && count_q == '0)
  // A successful removal returns the weight that slot zero held, with status OK.
  `ASSERT_PROP(a_deq_head, clk_i, rst_ni, cell_ctrl.deq |=> out_weight_q == $past(out_weight_d) && status_q == ST_OK)

endmodule

// ===== bench/tb_sorted_min_priority_queue.sv =====
// Self-checking bench for sorted_min_priority_queue: directed table, then random beats.
// Keeps its own sorted shadow queue; depends on smpq_pkg and the RTL top level only.
module tb_sorted_min_priority_queue;
  import smpq_pkg::*;

  // Expected fields of one output beat.
  typedef struct packed {
    logic [HANDLE_BITS-1:0]      handle;
    logic [WEIGHT_PORT_BITS-1:0] weight;
    logic [SYMBOL_BITS-1:0]      symbol;
    logic                        empty;
    logic                        single;
    status_e                     status;
  } result_t;

  // One input beat; rows with fixed set carry a hand-written expected result.
  typedef struct packed {
    op_e                         op;
    logic [HANDLE_BITS-1:0]      handle;
    logic [WEIGHT_PORT_BITS-1:0] weight;
    logic [SYMBOL_BITS-1:0]      symbol;
    logic                        fixed;
    result_t                     want;
  } row_t;

  localparam int STALL_LIMIT = 1000;
  localparam int SCRIPT_ROWS = 20;

  // Directed rows: extremes, equal keys, symbol tie-break, empty dequeues.
  localparam row_t SCRIPT [SCRIPT_ROWS] = '{
    '{OP_DEQ, 9'h000, 32'h0000_0000, 8'h00, 1'b1, '{9'h000, 32'h0, 8'h00, 1'b1, 1'b0, ST_EMPTY}},
    '{OP_ENQ, 9'h1FF, 32'hFFFF_FFFF, 8'hFF, 1'b1, '{9'h000, 32'h0, 8'h00, 1'b0, 1'b1, ST_OK}},
    '{OP_DEQ, 9'h000, 32'h0000_0000, 8'h00, 1'b1,
      '{9'h1FF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b0, ST_OK}},
    '{OP_ENQ, 9'h000, 32'h0000_0000, 8'h00, 1'b1, '{9'h000, 32'h0, 8'h00, 1'b0, 1'b1, ST_OK}},
    '{OP_ENQ, 9'h001, 32'h0000_0000, 8'h00, 1'b0, '0},
    '{OP_ENQ, 9'h002, 32'h0000_0005, 8'h03, 1'b0, '0},
    '{OP_ENQ, 9'h003, 32'h0000_0005, 8'h01, 1'b0, '0},
    '{OP_ENQ, 9'h004, 32'hFFFF_FFFF, 8'h00, 1'b0, '0},
    '{OP_ENQ, 9'h005, 32'h0000_0000, 8'hFF, 1'b0, '0},
    '{OP_ENQ, 9'h006, 32'h8000_0000, 8'h80, 1'b0, '0},
    '{OP_ENQ, 9'h100, 32'h0000_0001, 8'h00, 1'b0, '0},
    '{OP_DEQ, 9'h000, 32'h0000_0000, 8'h00, 1'b0, '0},
    '{OP_DEQ, 9'h000, 32'h0000_0000, 8'h00, 1'b0, '0},
    '{OP_DEQ, 9'h000, 32'h0000_0000, 8'h00, 1'b0, '0},
    '{OP_DEQ, 9'h000, 32'h0000_0000, 8'h00, 1'b0, '0},
    '{OP_DEQ, 9'h000, 32'h0000_0000, 8'h00, 1'b0, '0},
    '{OP_DEQ, 9'h000, 32'h0000_0000, 8'h00, 1'b0, '0},
    '{OP_DEQ, 9'h000, 32'h0000_0000, 8'h00, 1'b0, '0},
    '{OP_DEQ, 9'h000, 32'h0000_0000, 8'h00, 1'b0, '0},
    '{OP_DEQ, 9'h000, 32'h0000_0000, 8'h00, 1'b1, '{9'h000, 32'h0, 8'h00, 1'b1, 1'b0, ST_EMPTY}}
  };

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_stall_i = 1'b0;
  row_t cur_row     = '0;

  logic                        in_stall_o;
  logic                        out_valid_o;
  logic [HANDLE_BITS-1:0]      out_handle_o;
  logic [WEIGHT_PORT_BITS-1:0] out_weight_o;
  logic [SYMBOL_BITS-1:0]      out_symbol_o;
  logic                        now_empty_o;
  logic                        now_single_o;
  logic [1:0]                  status_o;

  entry_t      shadow_entries[$];
  result_t     awaited_results[$];
  int          mismatches   = 0;
  int          out_beats    = 0;
  int          quiet_cycles = 0;
  bit          idle_on      = 1'b1;
  int unsigned stall_left   = 0;

  always #10 clk_i = ~clk_i;

  sorted_min_priority_queue i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (cur_row.op),
    .node_handle_i (cur_row.handle),
    .weight_i      (cur_row.weight),
    .symbol_i      (cur_row.symbol),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_handle_o  (out_handle_o),
    .out_weight_o  (out_weight_o),
    .out_symbol_o  (out_symbol_o),
    .now_empty_o   (now_empty_o),
    .now_single_o  (now_single_o),
    .status_o      (status_o)
  );

  // Applies one beat to the shadow queue and returns the result it must produce.
  function automatic result_t predict_queue_result(row_t r);
    result_t res;
    entry_t  e;
    int      pos;
    res = '0;
    res.status = ST_OK;
    if (r.op == OP_ENQ) begin
      if (shadow_entries.size() >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        e.handle = r.handle;
        e.weight = r.weight[WEIGHT_BITS-1:0];
        e.symbol = r.symbol;
        // Walk past every entry that is not greater, so equal keys keep arrival order.
        pos = 0;
        while (pos < shadow_entries.size() &&
               (e.weight > shadow_entries[pos].weight ||
                (e.weight == shadow_entries[pos].weight &&
                 e.symbol >= shadow_entries[pos].symbol))) begin
          pos++;
        end
        shadow_entries.insert(pos, e);
      end
    end else if (shadow_entries.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      e = shadow_entries.pop_front();
      res.handle = e.handle;
      res.weight = e.weight;
      res.symbol = e.symbol;
    end
    res.empty  = (shadow_entries.size() == 0);
    res.single = (shadow_entries.size() == 1);
    return res;
  endfunction

  // Idle length: mostly short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      return $urandom_range(1, 3);
    end else if (pick < 93) begin
      return $urandom_range(4, 8);
    end
    return $urandom_range(9, 24);
  endfunction

  // Random beat; small weights and symbols are favored so that keys collide often.
  function automatic row_t random_item(int unsigned enq_pct);
    row_t r;
    int unsigned pick;
    r = '0;
    r.op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
    r.handle = HANDLE_BITS'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      r.weight = $urandom_range(0, 7);
    end else if (pick < 8) begin
      r.weight = $urandom;
    end else if (pick == 8) begin
      r.weight = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    end else begin
      r.weight = {1'b1, 31'($urandom_range(0, 3))};
    end
    r.symbol = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    return r;
  endfunction

  // Prints one line for each wrong field and counts it.
  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("beat %0d: %s is 0x%0h, expected 0x%0h", out_beats, field, got, want);
    mismatches++;
  endtask

  task automatic check_result(result_t got, result_t want);
    if (got.handle !== want.handle)
      report_mismatch("out_handle", 64'(got.handle), 64'(want.handle));
    if (got.weight !== want.weight)
      report_mismatch("out_weight", 64'(got.weight), 64'(want.weight));
    if (got.symbol !== want.symbol)
      report_mismatch("out_symbol", 64'(got.symbol), 64'(want.symbol));
    if (got.empty !== want.empty)
      report_mismatch("now_empty", 64'(got.empty), 64'(want.empty));
    if (got.single !== want.single)
      report_mismatch("now_single", 64'(got.single), 64'(want.single));
    if (got.status !== want.status)
      report_mismatch("status", 64'(got.status), 64'(want.status));
  endtask

  // Presents one beat after an optional gap and holds it until it is taken.
  task automatic send_item(row_t r);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cur_row    <= r;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Holds the input off until every expected result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  // Output stall: random stretches, no new one started while idling is switched off.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 99) < 30) begin
      stall_left = idle_len() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: predicts on every accepted input beat, checks every accepted output beat.
  always @(posedge clk_i) begin : monitor
    result_t predicted;
    result_t seen;
    if (rst_ni) begin
      quiet_cycles++;
      if (in_valid_i && !in_stall_o) begin
        predicted = predict_queue_result(cur_row);
        awaited_results.push_back(cur_row.fixed ? cur_row.want : predicted);
        quiet_cycles = 0;
      end
      if (out_valid_o && !out_stall_i) begin
        seen = '{out_handle_o, out_weight_o, out_symbol_o, now_empty_o, now_single_o,
                 status_e'(status_o)};
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected beat, status", 64'(seen.status), '0);
        end else begin
          check_result(seen, awaited_results.pop_front());
        end
        out_beats++;
        quiet_cycles = 0;
      end
    end
  end

  // Watchdog: ends the run when neither side has moved a beat for too long.
  initial begin
    do @(posedge clk_i); while (quiet_cycles < STALL_LIMIT);
    $display("[sorted_min_priority_queue] ERROR");
    $finish;
  end

  // Stimulus sequence.
  initial begin : stimulus
    int unsigned fill;
    int unsigned drain;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (SCRIPT[i]) send_item(SCRIPT[i]);

    // Mixed traffic around a shallow queue.
    repeat (200) send_item(random_item(55));

    // Fill to capacity back to back, then push against the full queue.
    wait_drained();
    idle_on = 1'b0;
    fill = CAPACITY - shadow_entries.size() + 5;
    repeat (fill) send_item(random_item(100));
    idle_on = 1'b1;

    // Churn near the top.
    repeat (100) send_item(random_item(50));

    // Drain everything in sorted order and keep dequeuing past empty.
    wait_drained();
    drain = shadow_entries.size() + 5;
    repeat (drain) send_item(random_item(0));

    // Churn near the bottom.
    repeat (150) send_item(random_item(45));

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[sorted_min_priority_queue] OK");
    end else begin
      $display("[sorted_min_priority_queue] ERROR");
    end
    $finish;
  end

endmodule

// ===== sorted_min_priority_queue.f =====
+incdir+rtl
rtl/smpq_pkg.sv
rtl/smpq_cell.sv
rtl/sorted_min_priority_queue.sv
bench/tb_sorted_min_priority_queue.sv
